// ===== rtl/core/wearable_activity_tracker_unit_assert.svh =====
// Assertion macros shared by the tracker checks.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef WEARABLE_ACTIVITY_TRACKER_UNIT_ASSERT_SVH
`define WEARABLE_ACTIVITY_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication
`define WAT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wat_pkg.sv =====
package wat_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_SAMPLE    = 3'd0,
    OP_CLR_SLEEP = 3'd1,
    OP_CLR_SED   = 3'd2,
    OP_CLR_STILL = 3'd3,
    OP_RESET     = 3'd4
  } op_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] REG_SCENE_ENABLE     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STANDSTILL_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SLEEP_DEADBAND   = 2'd2;

  // Scene enable bits
  localparam int unsigned SceneSleep = 0;
  localparam int unsigned SceneSed   = 1;
  localparam int unsigned SceneStill = 2;

  // Reset values and limits
  localparam logic [9:0]  LimitRst    = 10'd10;
  localparam logic [7:0]  DeadbandRst = 8'd2;
  localparam logic [5:0]  SecPerMin   = 6'd60;
  localparam logic [10:0] SedCap      = 11'd1440;
  localparam logic [14:0] StillCap    = 15'd18720;
  localparam logic [9:0]  MotionMax   = 10'd765;
  localparam logic [15:0] SleepSat    = 16'hffff;
  localparam logic [31:0] SedSat      = 32'hffff_ffff;

  // Reduced axis sample: signed top byte
  typedef logic signed [7:0] axis_t;

  // Control from the top level to the sleep tracker
  typedef struct packed {
    logic run;
    logic clear;
  } sleep_ctrl_t;

  // Absolute difference of two reduced samples
  function automatic logic [7:0] absdiff8(axis_t a, axis_t b);
    logic signed [8:0] d;
    logic signed [8:0] m;
    d = {a[7], a} - {b[7], b};
    m = d[8] ? -d : d;
    return m[7:0];
  endfunction

endpackage

// ===== rtl/core/wat_sleep.sv =====
module wat_sleep import wat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sleep_ctrl_t      ctrl_i,
  input  axis_t [2:0]      axis_i,
  input  logic [7:0]       deadband_i,
  output logic [15:0]      sleep_total_o
);

  logic        smooth_primed_q, smooth_primed_d;
  logic        sleep_primed_q, sleep_primed_d;
  axis_t [2:0] smooth_prev_q, smooth_prev_d;
  axis_t [2:0] sleep_old_q, sleep_old_d;
  logic [15:0] sleep_acc_q, sleep_acc_d;

  axis_t [2:0]       sm;
  logic [7:0]        diff [3];
  logic [9:0]        change;
  logic [16:0]       acc_sum;
  logic signed [8:0] pair_sum [3];
  logic signed [8:0] pair_adj [3];

  // Smooth each axis and sum the changes past the dead band
  always_comb begin
    change = '0;
    for (int i = 0; i < 3; i++) begin
      pair_sum[i] = {smooth_prev_q[i][7], smooth_prev_q[i]} + {axis_i[i][7], axis_i[i]};
      // round toward zero before halving
      pair_adj[i] = pair_sum[i] + {8'd0, pair_sum[i][8]};
      sm[i] = pair_adj[i][8:1];
      diff[i] = sleep_primed_q ? absdiff8(sm[i], sleep_old_q[i]) : 8'd0;
      if (diff[i] >= deadband_i) begin
        change = change + {2'd0, diff[i]};
      end
    end
    acc_sum = {1'b0, sleep_acc_q} + {7'd0, change};
  end

  // Advance the smoothing state and the saturating accumulator
  always_comb begin
    smooth_primed_d = smooth_primed_q;
    sleep_primed_d  = sleep_primed_q;
    smooth_prev_d   = smooth_prev_q;
    sleep_old_d     = sleep_old_q;
    sleep_acc_d     = sleep_acc_q;
    if (ctrl_i.clear) begin
      sleep_acc_d = '0;
    end else if (ctrl_i.run) begin
      if (!smooth_primed_q) begin
        smooth_prev_d   = axis_i;
        smooth_primed_d = 1'b1;
      end else begin
        smooth_prev_d  = sm;
        sleep_old_d    = sm;
        sleep_primed_d = 1'b1;
        sleep_acc_d    = acc_sum[16] ? SleepSat : acc_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_primed_q <= 1'b0;
      sleep_primed_q  <= 1'b0;
      smooth_prev_q   <= '0;
      sleep_old_q     <= '0;
      sleep_acc_q     <= '0;
    end else begin
      smooth_primed_q <= smooth_primed_d;
      sleep_primed_q  <= sleep_primed_d;
      smooth_prev_q   <= smooth_prev_d;
      sleep_old_q     <= sleep_old_d;
      sleep_acc_q     <= sleep_acc_d;
    end
  end

  assign sleep_total_o = sleep_acc_q;

endmodule

// ===== rtl/core/wearable_activity_tracker_unit.sv =====
// Activity tracker for one accelerometer sample per second.
// Input channel (in_valid_i / in_stall_o) carries an op code, three raw
// axis samples and the pedometer step total. Output channel (out_valid_o /
// out_stall_i) returns one result item per input item: the last motion
// value, sleep total, sedentary total and minutes, and standstill minutes,
// all as they stand after the op has been applied.
// An input register holds the item, one pass of logic updates the tracker
// state, and that state register is the result register.
// Throughput: one item per cycle while the output is not stalled.
// When the receiver stalls, the result holds, the input register still
// takes one more item, and in_stall_o rises only once both stages are full.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken; an
// index past the register list is ignored.
// Reset clears all tracker state, loads the register reset values and
// empties both stages; the first sample after reset only loads history.
module wearable_activity_tracker_unit import wat_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          op_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  logic [31:0]         step_count_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [9:0]          motion_o,
  output logic [15:0]         sleep_total_o,
  output logic [31:0]         sedentary_total_o,
  output logic [10:0]         sedentary_minutes_o,
  output logic [14:0]         standstill_minutes_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [2:0] scene_enable_q, scene_enable_d;
  logic [9:0] standstill_limit_q;
  logic [7:0] sleep_deadband_q;

  // Input stage
  logic        in_valid_q;
  logic [2:0]  op_q;
  axis_t [2:0] axis_q;
  logic [31:0] steps_q;

  // Tracker state
  logic        first_pending_q, first_pending_d;
  axis_t [2:0] prev_axis_q, prev_axis_d;
  logic [31:0] prev_steps_q, prev_steps_d;
  logic [9:0]  motion_q, motion_d;
  logic [31:0] sed_acc_q, sed_acc_d;
  logic [5:0]  sed_seconds_q, sed_seconds_d;
  logic [10:0] sed_minutes_q, sed_minutes_d;
  logic [5:0]  still_seconds_q, still_seconds_d;
  logic [14:0] still_minutes_q, still_minutes_d;
  logic        out_valid_q;

  logic        in_accept;
  logic        advance;
  logic        run;
  logic [9:0]  m;
  logic [32:0] sed_sum;
  logic [5:0]  sed_sec_inc;
  logic [5:0]  still_sec_inc;
  sleep_ctrl_t sleep_ctrl;

  // Handshakes: the input stage moves on when the result slot is free
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Capture the item, reducing each axis to its top byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept || (in_valid_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= op_i;
      axis_q[0] <= accel_x_i[15:8];
      axis_q[1] <= accel_y_i[15:8];
      axis_q[2] <= accel_z_i[15:8];
      steps_q   <= step_count_i;
    end
  end

  // Motion against the previous reduced sample
  always_comb begin
    m = '0;
    for (int i = 0; i < 3; i++) begin
      m = m + {2'd0, absdiff8(prev_axis_q[i], axis_q[i])};
    end
  end

  assign run           = advance && (op_q == OP_SAMPLE) && !first_pending_q;
  assign sed_sum       = {1'b0, sed_acc_q} + {23'd0, m};
  assign sed_sec_inc   = sed_seconds_q + 6'd1;
  assign still_sec_inc = still_seconds_q + 6'd1;

  // Sleep tracker control
  assign sleep_ctrl.run   = run && scene_enable_q[SceneSleep];
  assign sleep_ctrl.clear = advance && ((op_q == OP_CLR_SLEEP) || (op_q == OP_RESET));

  wat_sleep u_sleep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (sleep_ctrl),
    .axis_i        (axis_q),
    .deadband_i    (sleep_deadband_q),
    .sleep_total_o (sleep_total_o)
  );

  // Next tracker state for the item in the input stage
  always_comb begin
    first_pending_d = first_pending_q;
    prev_axis_d     = prev_axis_q;
    prev_steps_d    = prev_steps_q;
    motion_d        = motion_q;
    sed_acc_d       = sed_acc_q;
    sed_seconds_d   = sed_seconds_q;
    sed_minutes_d   = sed_minutes_q;
    still_seconds_d = still_seconds_q;
    still_minutes_d = still_minutes_q;
    scene_enable_d  = scene_enable_q;
    if (advance) begin
      case (op_q)
        OP_SAMPLE: begin
          first_pending_d = 1'b0;
          prev_axis_d     = axis_q;
          prev_steps_d    = steps_q;
          if (!first_pending_q) begin
            motion_d = m;
            // sedentary: stillness of the step total
            if (scene_enable_q[SceneSed]) begin
              if (steps_q != prev_steps_q) begin
                sed_acc_d     = '0;
                sed_seconds_d = '0;
                sed_minutes_d = '0;
              end else begin
                sed_acc_d = sed_sum[32] ? SedSat : sed_sum[31:0];
                if (sed_sec_inc >= SecPerMin) begin
                  sed_seconds_d = '0;
                  if (sed_minutes_q < SedCap) begin
                    sed_minutes_d = sed_minutes_q + 11'd1;
                  end
                end else begin
                  sed_seconds_d = sed_sec_inc;
                end
              end
            end
            // standstill: motion under the limit
            if (scene_enable_q[SceneStill]) begin
              if (m < standstill_limit_q) begin
                if (still_sec_inc >= SecPerMin) begin
                  still_seconds_d = '0;
                  if (still_minutes_q < StillCap) begin
                    still_minutes_d = still_minutes_q + 15'd1;
                  end
                end else begin
                  still_seconds_d = still_sec_inc;
                end
              end else begin
                still_seconds_d = '0;
                still_minutes_d = '0;
              end
            end
          end
        end
        OP_CLR_SED: begin
          sed_acc_d     = '0;
          sed_seconds_d = '0;
          sed_minutes_d = '0;
        end
        OP_CLR_STILL: begin
          still_seconds_d = '0;
          still_minutes_d = '0;
        end
        OP_RESET: begin
          first_pending_d = 1'b1;
          prev_axis_d     = '0;
          prev_steps_d    = '0;
          motion_d        = '0;
          sed_acc_d       = '0;
          sed_seconds_d   = '0;
          sed_minutes_d   = '0;
          still_seconds_d = '0;
          still_minutes_d = '0;
          scene_enable_d  = '0;
        end
        default: begin
          // sleep clear is handled in the sleep tracker; others do nothing
        end
      endcase
    end
  end

  // Tracker state doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pending_q <= 1'b1;
      prev_axis_q     <= '0;
      prev_steps_q    <= '0;
      motion_q        <= '0;
      sed_acc_q       <= '0;
      sed_seconds_q   <= '0;
      sed_minutes_q   <= '0;
      still_seconds_q <= '0;
      still_minutes_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      first_pending_q <= first_pending_d;
      prev_axis_q     <= prev_axis_d;
      prev_steps_q    <= prev_steps_d;
      motion_q        <= motion_d;
      sed_acc_q       <= sed_acc_d;
      sed_seconds_q   <= sed_seconds_d;
      sed_minutes_q   <= sed_minutes_d;
      still_seconds_q <= still_seconds_d;
      still_minutes_q <= still_minutes_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers; the reset op also drops scene_enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scene_enable_q     <= '0;
      standstill_limit_q <= LimitRst;
      sleep_deadband_q   <= DeadbandRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SCENE_ENABLE:     scene_enable_q     <= cfg_data_i[2:0];
        REG_STANDSTILL_LIMIT: standstill_limit_q <= cfg_data_i[9:0];
        REG_SLEEP_DEADBAND:   sleep_deadband_q   <= cfg_data_i[7:0];
        default: begin
          // no register at this index
        end
      endcase
    end else begin
      scene_enable_q <= scene_enable_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign motion_o             = motion_q;
  assign sedentary_total_o    = sed_acc_q;
  assign sedentary_minutes_o  = sed_minutes_q;
  assign standstill_minutes_o = still_minutes_q;

endmodule

// ===== rtl/core/wat_checker.sv =====
`include "wearable_activity_tracker_unit_assert.svh"

module wat_checker import wat_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [9:0]  motion_o,
  input logic [15:0] sleep_total_o,
  input logic [31:0] sedentary_total_o,
  input logic [10:0] sedentary_minutes_o,
  input logic [14:0] standstill_minutes_o
);

  logic [83:0] out_fields;

  // Gather every result field for the hold check
  assign out_fields = {motion_o, sleep_total_o, sedentary_total_o,
                       sedentary_minutes_o, standstill_minutes_o};

  // A stalled result stays offered
  `WAT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // A stalled result keeps every field
  `WAT_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_fields), "result changed")

  // Minute counters respect their caps
  `WAT_ASSERT_IMPL(a_sed_cap, out_valid_o, sedentary_minutes_o <= SedCap, "sedentary over cap")

  `WAT_ASSERT_IMPL(a_still_cap, out_valid_o, standstill_minutes_o <= StillCap, "standstill over cap")

  // Motion is bounded by three full byte swings
  `WAT_ASSERT_IMPL(a_motion_max, out_valid_o, motion_o <= MotionMax, "motion out of range")

endmodule

bind wearable_activity_tracker_unit wat_checker u_wat_checker (.*);

// ===== tb/tb_wearable_activity_tracker_unit.sv =====
`timescale 1ns / 100ps

module tb_wearable_activity_tracker_unit;
  import wat_pkg::*;

  // Latency from accept to result; wait_idle adds margin for the final drain
  localparam int Latency = 1;
  // Index past the register list: the block must ignore it
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  // Op codes without meaning
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  typedef struct {
    logic [9:0]  motion;
    logic [15:0] sleep_total;
    logic [31:0] sed_total;
    logic [10:0] sed_minutes;
    logic [14:0] still_minutes;
  } totals_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [2:0]          op_i;
  logic signed [15:0]  accel_x_i;
  logic signed [15:0]  accel_y_i;
  logic signed [15:0]  accel_z_i;
  logic [31:0]         step_count_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [9:0]          motion_o;
  logic [15:0]         sleep_total_o;
  logic [31:0]         sedentary_total_o;
  logic [10:0]         sedentary_minutes_o;
  logic [14:0]         standstill_minutes_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_cnt;
  totals_t pending_totals[$];

  // Register values of the current phase, restored after a reset op
  logic [2:0] phase_scene;
  logic [9:0] phase_limit;
  logic [7:0] phase_db;

  // Predicted tracker state
  logic [2:0]  scene_q;
  logic [9:0]  limit_q;
  logic [7:0]  deadband_q;
  bit          first_q;
  int          prev_axis_q[3];
  logic [31:0] prev_steps_q;
  int          motion_q;
  bit          smooth_rdy_q;
  int          smooth_q[3];
  bit          sleep_rdy_q;
  int          sleep_old_q[3];
  int          sleep_acc_q;
  logic [31:0] sed_acc_q;
  int          sed_sec_q;
  int          sed_min_q;
  int          still_sec_q;
  int          still_min_q;

  wearable_activity_tracker_unit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .op_i                (op_i),
    .accel_x_i           (accel_x_i),
    .accel_y_i           (accel_y_i),
    .accel_z_i           (accel_z_i),
    .step_count_i        (step_count_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .motion_o            (motion_o),
    .sleep_total_o       (sleep_total_o),
    .sedentary_total_o   (sedentary_total_o),
    .sedentary_minutes_o (sedentary_minutes_o),
    .standstill_minutes_o(standstill_minutes_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Tracker prediction
  // ---------------------------------------------------------------------

  // Drop history and every counter, as reset and the reset op do
  function automatic void clear_history();
    first_q = 1'b1;
    prev_axis_q = '{0, 0, 0};
    prev_steps_q = '0;
    motion_q = 0;
    sleep_acc_q = 0;
    sed_acc_q = '0;
    sed_sec_q = 0;
    sed_min_q = 0;
    still_sec_q = 0;
    still_min_q = 0;
  endfunction

  function automatic void init_tracker();
    scene_q = '0;
    limit_q = LimitRst;
    deadband_q = DeadbandRst;
    clear_history();
    smooth_rdy_q = 1'b0;
    sleep_rdy_q = 1'b0;
    smooth_q = '{0, 0, 0};
    sleep_old_q = '{0, 0, 0};
  endfunction

  function automatic int axis_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Average each axis with its last smoothed value and sum changes outside the dead band
  function automatic void update_sleep(int ax[3]);
    int sm[3];
    int change;
    int d;
    change = 0;
    if (!smooth_rdy_q) begin
      smooth_q = ax;
      smooth_rdy_q = 1'b1;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      sm[i] = (smooth_q[i] + ax[i]) / 2;
      smooth_q[i] = sm[i];
    end
    if (!sleep_rdy_q) begin
      sleep_old_q = sm;
      sleep_rdy_q = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      d = axis_gap(sm[i], sleep_old_q[i]);
      if (d >= deadband_q) change += d;
      sleep_old_q[i] = sm[i];
    end
    sleep_acc_q += change;
    if (sleep_acc_q > SleepSat) sleep_acc_q = int'(SleepSat);
  endfunction

  function automatic void take_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                      logic [31:0] steps);
    int ax[3];
    int m;
    longint unsigned sum;
    ax[0] = int'($signed(x[15:8]));
    ax[1] = int'($signed(y[15:8]));
    ax[2] = int'($signed(z[15:8]));
    if (first_q) begin
      first_q = 1'b0;
    end else begin
      m = 0;
      for (int i = 0; i < 3; i++) m += axis_gap(prev_axis_q[i], ax[i]);
      motion_q = m;

      if (scene_q[SceneSleep]) update_sleep(ax);

      // Sedentary: any step change restarts the count
      if (scene_q[SceneSed]) begin
        if (steps != prev_steps_q) begin
          sed_sec_q = 0;
          sed_min_q = 0;
          sed_acc_q = '0;
        end else begin
          sum = {32'd0, sed_acc_q} + 64'(m);
          sed_acc_q = (sum > SedSat) ? SedSat : sum[31:0];
          sed_sec_q++;
          if (sed_sec_q >= SecPerMin) begin
            sed_sec_q = 0;
            sed_min_q++;
            if (sed_min_q > SedCap) sed_min_q = int'(SedCap);
          end
        end
      end

      // Standstill: motion at or above the limit restarts the count
      if (scene_q[SceneStill]) begin
        if (m < limit_q) begin
          still_sec_q++;
          if (still_sec_q >= SecPerMin) begin
            still_sec_q = 0;
            still_min_q++;
            if (still_min_q > StillCap) still_min_q = int'(StillCap);
          end
        end else begin
          still_sec_q = 0;
          still_min_q = 0;
        end
      end
    end
    prev_axis_q = ax;
    prev_steps_q = steps;
  endfunction

  function automatic totals_t track_item(logic [2:0] op, logic [15:0] x, logic [15:0] y,
                                         logic [15:0] z, logic [31:0] steps);
    totals_t t;
    case (op)
      OP_SAMPLE:    take_sample(x, y, z, steps);
      OP_CLR_SLEEP: sleep_acc_q = 0;
      OP_CLR_SED: begin
        sed_sec_q = 0;
        sed_min_q = 0;
        sed_acc_q = '0;
      end
      OP_CLR_STILL: begin
        still_sec_q = 0;
        still_min_q = 0;
      end
      OP_RESET: begin
        clear_history();
        scene_q = '0;
      end
      default: ;
    endcase
    t.motion = motion_q[9:0];
    t.sleep_total = sleep_acc_q[15:0];
    t.sed_total = sed_acc_q;
    t.sed_minutes = sed_min_q[10:0];
    t.still_minutes = still_min_q[14:0];
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin : compare_totals
    totals_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_totals.size() == 0) begin
        if (mismatch_cnt < 10) $display("result item with none expected at %0t", $time);
        mismatch_cnt++;
      end else begin
        want = pending_totals.pop_front();
        if (want.motion !== motion_o || want.sleep_total !== sleep_total_o ||
            want.sed_total !== sedentary_total_o || want.sed_minutes !== sedentary_minutes_o ||
            want.still_minutes !== standstill_minutes_o) begin
          if (mismatch_cnt < 10) begin
            $display("mismatch at %0t: motion %0d/%0d sleep %0d/%0d sed %0d/%0d",
                     $time, want.motion, motion_o, want.sleep_total, sleep_total_o,
                     want.sed_total, sedentary_total_o);
            $display("  sed_min %0d/%0d still_min %0d/%0d (expected/actual)",
                     want.sed_minutes, sedentary_minutes_o,
                     want.still_minutes, standstill_minutes_o);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Send one item, idling first at random, and predict its result
  task automatic send_item(input logic [2:0] op, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic [31:0] steps);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    accel_x_i <= x;
    accel_y_i <= y;
    accel_z_i <= z;
    step_count_i <= steps;
    do @(posedge clk_i); while (in_stall_o);
    pending_totals.push_back(track_item(op, x, y, z, steps));
  endtask

  // Hold off until every result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  // Write registers back to back, then the spare index; pad scene and deadband randomly
  task automatic program_regs(input logic [2:0] scene, input logic [9:0] limit,
                              input logic [7:0] db);
    logic [CfgIdxW-1:0]  idx[4];
    logic [CfgDataW-1:0] val[4];
    logic [6:0]          pad_hi;
    logic [1:0]          pad_lo;
    pad_hi = 7'($urandom);
    pad_lo = 2'($urandom);
    idx = '{REG_SCENE_ENABLE, REG_STANDSTILL_LIMIT, REG_SLEEP_DEADBAND, RegSpare};
    val[0] = {pad_hi, scene};
    val[1] = limit;
    val[2] = {pad_lo, db};
    val[3] = CfgDataW'($urandom);
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[k])
        REG_SCENE_ENABLE:     scene_q = val[k][2:0];
        REG_STANDSTILL_LIMIT: limit_q = val[k][9:0];
        REG_SLEEP_DEADBAND:   deadband_q = val[k][7:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Bursts of still, walking and wild motion, with control ops mixed in
  task automatic run_activity(input int n_items);
    int          sent;
    int          kind;
    int          len;
    int          jit;
    int          pick;
    int          j;
    logic [7:0]  base[3];
    logic [7:0]  top;
    logic [15:0] raw[3];
    logic [31:0] steps;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      steps = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000);
      for (int i = 0; i < 3; i++) base[i] = 8'($urandom);
      if (kind < 40) begin
        len = $urandom_range(150, 40);
        jit = $urandom_range(2);
      end else if (kind < 70) begin
        len = $urandom_range(60, 10);
        jit = $urandom_range(24, 3);
      end else begin
        len = $urandom_range(40, 5);
        jit = -1;
      end
      for (int r = 0; r < len && sent < n_items; r++) begin
        pick = $urandom_range(999);
        if (pick < 9) begin
          send_item(3'($urandom_range(OP_CLR_STILL, OP_CLR_SLEEP)), 16'($urandom),
                    16'($urandom), 16'($urandom), $urandom);
        end else if (pick < 12) begin
          send_item(3'($urandom_range(OpSpareHi, OpSpareLo)), 16'($urandom),
                    16'($urandom), 16'($urandom), $urandom);
        end else if (pick < 14) begin
          // Reset op disables every scene: restore the phase setting
          send_item(OP_RESET, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
          wait_idle();
          program_regs(phase_scene, phase_limit, phase_db);
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (jit < 0) begin
              raw[i] = 16'($urandom);
            end else begin
              j = int'($urandom_range(2 * jit)) - jit;
              top = base[i] + j[7:0];
              raw[i] = {top, 8'($urandom)};
            end
          end
          if (jit < 0) begin
            if ($urandom_range(1)) steps = $urandom;
          end else if (jit > 2 && $urandom_range(3) == 0) begin
            steps = steps + $urandom_range(2, 1);
          end
          send_item(OP_SAMPLE, raw[0], raw[1], raw[2], steps);
        end
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // First sample, full-scale swings, truncation of negative averages, step change
  task automatic test_axis_extremes();
    program_regs(3'b111, LimitRst, DeadbandRst);
    send_item(OP_SAMPLE, 16'h8000, 16'h7fff, 16'h00ff, 32'd0);
    send_item(OP_SAMPLE, 16'h7fff, 16'h8000, 16'hff00, 32'd0);
    send_item(OP_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, 32'd0);
    send_item(OP_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, 32'd0);
    send_item(OP_SAMPLE, 16'hff00, 16'h0100, 16'h80ff, 32'd0);
    send_item(OP_SAMPLE, 16'hff00, 16'h0100, 16'h80ff, 32'hffff_ffff);
    send_item(OP_SAMPLE, 16'hffff, 16'h01aa, 16'h8055, 32'hffff_ffff);
    send_item(OP_SAMPLE, 16'h7f00, 16'h7fff, 16'h7f80, 32'hffff_ffff);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    wait_idle();
  endtask

  // Each clear op, the ops without meaning, and the reset op
  task automatic test_control_ops();
    program_regs(3'b111, 10'd12, 8'd1);
    repeat (3) send_item(OP_SAMPLE, 16'h1234, 16'hedcb, 16'h0042, 32'd7);
    send_item(OP_CLR_SLEEP, 16'hffff, 16'h0000, 16'h5a5a, 32'h0f0f_0f0f);
    send_item(OP_CLR_SED, 16'h0000, 16'hffff, 16'ha5a5, 32'hf0f0_f0f0);
    send_item(OP_CLR_STILL, 16'h1234, 16'hedcb, 16'h0042, 32'd7);
    for (int k = OpSpareLo; k <= OpSpareHi; k++) begin
      send_item(k[2:0], 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    end
    send_item(OP_RESET, 16'h8000, 16'h8000, 16'h8000, 32'hffff_ffff);
    send_item(OP_SAMPLE, 16'h4000, 16'hc000, 16'h0000, 32'd1);
    send_item(OP_SAMPLE, 16'h3f00, 16'hc100, 16'h0100, 32'd1);
    wait_idle();
  endtask

  task automatic test_activity_phase(input logic [2:0] scene, input logic [9:0] limit,
                                     input logic [7:0] db, input int n_items);
    phase_scene = scene;
    phase_limit = limit;
    phase_db = db;
    program_regs(scene, limit, db);
    run_activity(n_items);
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_SAMPLE;
    accel_x_i = '0;
    accel_y_i = '0;
    accel_z_i = '0;
    step_count_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_SCENE_ENABLE;
    cfg_data_i = '0;
    mismatch_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    init_tracker();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    set_idling(32, 52);
    test_axis_extremes();
    test_control_ops();
    test_activity_phase(3'b111, 10'd10, 8'd2, 150);
    test_activity_phase(3'b111, 10'd0, 8'd0, 150);
    test_activity_phase(3'b111, MotionMax, 8'd255, 150);
    test_activity_phase(3'b011, 10'($urandom_range(40)), 8'($urandom_range(255)), 150);

    set_idling(52, 32);
    test_activity_phase(3'b111, 10'd1, 8'd1, 150);
    test_activity_phase(3'b101, 10'd20, 8'd4, 150);
    test_activity_phase(3'b110, 10'd3, 8'd8, 150);
    test_activity_phase(3'($urandom_range(7)), 10'($urandom_range(765)),
                        8'($urandom_range(16)), 150);

    set_idling(0, 0);
    test_activity_phase(3'b111, 10'd10, 8'd2, 150);
    test_activity_phase(3'b001, 10'd30, 8'd0, 150);
    test_activity_phase(3'b111, 10'd50, 8'd3, 150);

    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
